// ----- rtl/core/csc_pkg.sv -----
// Shared types, constants and helper functions for the calendar seconds converter.
// Used by csc_ctrl, csc_dp and calendar_seconds_converter_top; depends on nothing.
package csc_pkg;

    localparam int EPOCH_YEAR_DEF = 1999;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int SECS_W   = 32;

    localparam logic [SECS_W-1:0]  SECS_PER_DAY    = 32'd86400;
    localparam logic [SECS_W-1:0]  SECS_PER_HOUR   = 32'd3600;
    localparam logic [SECS_W-1:0]  SECS_PER_MIN    = 32'd60;
    localparam logic [SECS_W-1:0]  DAYS_YEAR       = 32'd365;
    localparam logic [SECS_W-1:0]  DAYS_LEAP       = 32'd366;
    localparam logic [SECS_W-1:0]  SECS_YEAR       = 32'd31536000;
    localparam logic [SECS_W-1:0]  SECS_LEAP       = 32'd31622400;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

    // Reciprocals for the divisions by the odd part of each constant: 86400 = 128 * 675,
    // 3600 = 16 * 225 and 60 = 4 * 15. Each is rounded up at a shift of 24, 20 and 14 bits,
    // which is exact over the remainders that reach each step.
    localparam logic [14:0] DAY_RECIP  = 15'd24856;
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY_ADD,
        ST_MUL,
        ST_SUM,
        ST_DIV_DAY,
        ST_REM_DAY,
        ST_DIV_HOUR,
        ST_REM_HOUR,
        ST_DIV_MIN,
        ST_REM_MIN,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_YEAR,
        DP_MONTH,
        DP_DAY_ADD,
        DP_MUL,
        DP_SUM,
        DP_QUOT,
        DP_REM,
        DP_PUSH
    } t_dp_op;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_div_sel;

    typedef struct packed {
        t_dp_op   op;
        t_div_sel dsel;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic year_more;
        logic month_more;
        logic out_full;
    } t_sts;

    // Month length in days; February follows the leap flag, codes outside 1..12 give zero.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        d = 5'd0;
        case (m) inside
            4'd2: begin
                d = leap ? 5'd29 : 5'd28;
            end
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                d = 5'd31;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                d = 5'd30;
            end
            default: begin
                d = 5'd0;
            end
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/csc_dp.sv -----
// Datapath of the calendar seconds converter: operand registers, year and month
// stepping, day multiply, reciprocal divisions and the output register. Uses csc_pkg.
module csc_dp import csc_pkg::*; #(
    parameter int EPOCH_YEAR = EPOCH_YEAR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_op,
    input  logic [YEAR_W-1:0]   i_year_in,
    input  logic [MONTH_W-1:0]  i_month_in,
    input  logic [DAY_W-1:0]    i_day_in,
    input  logic [HOUR_W-1:0]   i_hour_in,
    input  logic [MINUTE_W-1:0] i_minute_in,
    input  logic [SECOND_W-1:0] i_second_in,
    input  logic [SECS_W-1:0]   i_seconds_in,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [SECS_W-1:0]   o_seconds_out,
    output logic [YEAR_W-1:0]   o_year_out,
    output logic [MONTH_W-1:0]  o_month_out,
    output logic [DAY_W-1:0]    o_day_out,
    output logic [HOUR_W-1:0]   o_hour_out,
    output logic [MINUTE_W-1:0] o_minute_out,
    output logic [SECOND_W-1:0] o_second_out
);

    localparam logic [YEAR_W-1:0] EPOCH_Y    = YEAR_W'(EPOCH_YEAR);
    localparam logic [6:0]        EPOCH_C100 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0]        EPOCH_C400 = 9'(EPOCH_YEAR % 400);

    logic                r_op;
    logic                r_zero;
    logic [YEAR_W-1:0]   r_yr;
    logic [MONTH_W-1:0]  r_mo;
    logic [DAY_W-1:0]    r_dy;
    logic [HOUR_W-1:0]   r_hr;
    logic [MINUTE_W-1:0] r_mi;
    logic [SECOND_W-1:0] r_se;
    logic [SECS_W-1:0]   r_secs;
    logic [YEAR_W-1:0]   r_y;
    logic [6:0]          r_c100;
    logic [8:0]          r_c400;
    logic [MONTH_W-1:0]  r_m;
    logic [DAY_W-1:0]    r_q_day;
    logic [HOUR_W-1:0]   r_q_hour;
    logic [MINUTE_W-1:0] r_q_min;
    logic                r_out_valid;
    logic [SECS_W-1:0]   r_o_seconds;
    logic [YEAR_W-1:0]   r_o_year;
    logic [MONTH_W-1:0]  r_o_month;
    logic [DAY_W-1:0]    r_o_day;
    logic [HOUR_W-1:0]   r_o_hour;
    logic [MINUTE_W-1:0] r_o_minute;
    logic [SECOND_W-1:0] r_o_second;

    logic                w_leap;
    logic [DAY_W-1:0]    w_mdays;
    logic [SECS_W-1:0]   w_year_secs;
    logic [SECS_W-1:0]   w_month_secs;
    logic [SECS_W-1:0]   w_hms;
    logic [29:0]         w_day_prod;
    logic [25:0]         w_hour_prod;
    logic [20:0]         w_min_prod;
    logic [SECS_W-1:0]   w_div_sub;

    // The year's remainders by 100 and 400 run alongside the year, so the leap test needs
    // no division.
    assign w_leap       = ((r_y[1:0] == 2'd0) && (r_c100 != 7'd0)) || (r_c400 == 9'd0);
    assign w_mdays      = month_days(r_m, w_leap);
    assign w_year_secs  = w_leap ? SECS_LEAP : SECS_YEAR;
    assign w_month_secs = SECS_W'(w_mdays) * SECS_PER_DAY;
    assign w_hms        = (SECS_W'(r_hr) * SECS_PER_HOUR) + (SECS_W'(r_mi) * SECS_PER_MIN)
                        + SECS_W'(r_se);

    // The power-of-two part of each divisor is shifted off first. The remainder is below
    // 31 days at the day step, below a day at the hour step and below an hour at the
    // minute step, so the dropped high bits are zero.
    assign w_day_prod  = 30'(r_secs[21:7]) * 30'(DAY_RECIP);
    assign w_hour_prod = 26'(r_secs[16:4]) * 26'(HOUR_RECIP);
    assign w_min_prod  = 21'(r_secs[11:2]) * 21'(MIN_RECIP);

    always_comb begin
        case (i_cmd.dsel)
            DIV_DAY:  w_div_sub = SECS_W'(r_q_day) * SECS_PER_DAY;
            DIV_HOUR: w_div_sub = SECS_W'(r_q_hour) * SECS_PER_HOUR;
            DIV_MIN:  w_div_sub = SECS_W'(r_q_min) * SECS_PER_MIN;
            default:  w_div_sub = SECS_W'(r_q_min) * SECS_PER_MIN;
        endcase
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.year_more  = r_op ? ((r_secs != '0) && (r_secs >= w_year_secs)) : (r_y < r_yr);
        o_sts.month_more = r_op ? ((r_secs != '0) && (r_m <= MONTHS_PER_YEAR)
                                   && (r_secs >= w_month_secs))
                                : (r_m < r_mo);
        o_sts.out_full   = r_out_valid && !i_ready;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_op     <= i_op;
                r_zero   <= (i_year_in == '0) && (i_month_in == '0) && (i_day_in == '0)
                            && (i_hour_in == '0) && (i_minute_in == '0)
                            && (i_second_in == '0);
                r_yr     <= i_year_in;
                r_mo     <= i_month_in;
                r_dy     <= i_day_in;
                r_hr     <= i_hour_in;
                r_mi     <= i_minute_in;
                r_se     <= i_second_in;
                r_secs   <= i_op ? i_seconds_in : '0;
                r_y      <= EPOCH_Y;
                r_c100   <= EPOCH_C100;
                r_c400   <= EPOCH_C400;
                r_m      <= 4'd1;
                r_q_day  <= '0;
                r_q_hour <= '0;
                r_q_min  <= '0;
            end
            DP_YEAR: begin
                if (r_op) begin
                    r_secs <= r_secs - w_year_secs;
                end else begin
                    r_secs <= r_secs + (w_leap ? DAYS_LEAP : DAYS_YEAR);
                end
                r_y    <= r_y + 1'b1;
                r_c100 <= (r_c100 == 7'd99) ? 7'd0 : r_c100 + 1'b1;
                r_c400 <= (r_c400 == 9'd399) ? 9'd0 : r_c400 + 1'b1;
            end
            DP_MONTH: begin
                if (r_op) begin
                    r_secs <= r_secs - w_month_secs;
                end else begin
                    r_secs <= r_secs + SECS_W'(w_mdays);
                end
                r_m <= r_m + 1'b1;
            end
            DP_DAY_ADD: begin
                // Day zero wraps the day count, as the unsigned arithmetic does.
                r_secs <= r_secs + SECS_W'(r_dy) - SECS_W'(1);
            end
            DP_MUL: begin
                r_secs <= r_secs * SECS_PER_DAY;
            end
            DP_SUM: begin
                r_secs <= r_zero ? '0 : r_secs + w_hms;
            end
            DP_QUOT: begin
                case (i_cmd.dsel)
                    DIV_DAY:  r_q_day  <= w_day_prod[28:24];
                    DIV_HOUR: r_q_hour <= w_hour_prod[24:20];
                    DIV_MIN:  r_q_min  <= w_min_prod[19:14];
                    default:  r_q_min  <= r_q_min;
                endcase
            end
            DP_REM: begin
                r_secs <= r_secs - w_div_sub;
            end
            DP_PUSH: begin
                if (r_op) begin
                    r_o_seconds <= '0;
                    r_o_year    <= r_y;
                    r_o_month   <= r_m;
                    r_o_day     <= r_q_day + 1'b1;
                    r_o_hour    <= r_q_hour;
                    r_o_minute  <= r_q_min;
                    r_o_second  <= r_secs[SECOND_W-1:0];
                end else begin
                    r_o_seconds <= r_secs;
                    r_o_year    <= '0;
                    r_o_month   <= '0;
                    r_o_day     <= '0;
                    r_o_hour    <= '0;
                    r_o_minute  <= '0;
                    r_o_second  <= '0;
                end
            end
            default: begin
                r_secs <= r_secs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_PUSH) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_seconds_out = r_o_seconds;
    assign o_year_out    = r_o_year;
    assign o_month_out   = r_o_month;
    assign o_day_out     = r_o_day;
    assign o_hour_out    = r_o_hour;
    assign o_minute_out  = r_o_minute;
    assign o_second_out  = r_o_second;

    // A year step while splitting a seconds count must always shrink the remainder.
    a_year_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_YEAR) && r_op |=> (r_secs < $past(r_secs)))
        else $error("year step did not reduce the remaining seconds");

    // The result register is only loaded when the previous result has gone or is leaving.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_PUSH) |-> !(r_out_valid && !i_ready))
        else $error("result register overwritten while still held");

    // The divisions leave a legal time of day in every result.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_PUSH) |=> (r_o_hour < 5'd24) && (r_o_minute < 6'd60)
                                  && (r_o_second < 6'd60))
        else $error("time of day out of range");

endmodule

// ----- rtl/core/csc_ctrl.sv -----
// Controller of the calendar seconds converter: sequences year, month, multiply and
// division steps and the result hand-off. Uses csc_pkg; drives csc_dp by command.
module csc_ctrl import csc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.op   = DP_NOP;
        o_cmd.dsel = DIV_DAY;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (i_sts.year_more) begin
                    o_cmd.op = DP_YEAR;
                end else begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (i_sts.month_more) begin
                    o_cmd.op = DP_MONTH;
                end else if (i_sts.op) begin
                    n_state = ST_DIV_DAY;
                end else begin
                    n_state = ST_DAY_ADD;
                end
            end
            ST_DAY_ADD: begin
                o_cmd.op = DP_DAY_ADD;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = DP_MUL;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.op = DP_SUM;
                n_state  = ST_DONE;
            end
            ST_DIV_DAY: begin
                o_cmd.op   = DP_QUOT;
                o_cmd.dsel = DIV_DAY;
                n_state    = ST_REM_DAY;
            end
            ST_REM_DAY: begin
                o_cmd.op   = DP_REM;
                o_cmd.dsel = DIV_DAY;
                n_state    = ST_DIV_HOUR;
            end
            ST_DIV_HOUR: begin
                o_cmd.op   = DP_QUOT;
                o_cmd.dsel = DIV_HOUR;
                n_state    = ST_REM_HOUR;
            end
            ST_REM_HOUR: begin
                o_cmd.op   = DP_REM;
                o_cmd.dsel = DIV_HOUR;
                n_state    = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
                o_cmd.op   = DP_QUOT;
                o_cmd.dsel = DIV_MIN;
                n_state    = ST_REM_MIN;
            end
            ST_REM_MIN: begin
                o_cmd.op   = DP_REM;
                o_cmd.dsel = DIV_MIN;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // Wait here only while the previous result is still held downstream.
                if (!i_sts.out_full) begin
                    o_cmd.op = DP_PUSH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // An accepted transfer always starts with the year phase.
    a_start_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_YEAR))
        else $error("accepted item did not start the year phase");

    // The day quotient is always followed by its remainder step.
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_DAY) |=> (r_state == ST_REM_DAY))
        else $error("day quotient not followed by its remainder step");

endmodule

// ----- rtl/core/calendar_seconds_converter_top.sv -----
// Top level of the calendar seconds converter: ties the controller to the datapath.
// Uses csc_pkg, csc_ctrl and csc_dp.
//
// Converts between a Gregorian date and time and a 32-bit count of seconds since
// EPOCH_YEAR-01-01 00:00:00. With op 0 the date fields give seconds_out (wrapping modulo
// 2^32, an all-zero date gives zero); with op 1 seconds_in gives the date fields. Unused
// result fields are zero. One item is worked at a time by a shared adder that steps one
// year or one month per cycle. Op 0 steps the years from EPOCH_YEAR and the months before
// the given one, then adds the day, multiplies by the seconds of a day and adds the time
// of day, so far-future years are slow. Op 1 removes whole years and whole months, then
// makes three divisions by a constant, each a quotient step by reciprocal multiplication
// and a remainder step. A new item is taken once the previous one has reached the output
// register, even while that result still waits to be taken.
module calendar_seconds_converter_top import csc_pkg::*; #(
    parameter int EPOCH_YEAR = EPOCH_YEAR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic [YEAR_W-1:0]   i_year_in,
    input  logic [MONTH_W-1:0]  i_month_in,
    input  logic [DAY_W-1:0]    i_day_in,
    input  logic [HOUR_W-1:0]   i_hour_in,
    input  logic [MINUTE_W-1:0] i_minute_in,
    input  logic [SECOND_W-1:0] i_second_in,
    input  logic [SECS_W-1:0]   i_seconds_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SECS_W-1:0]   o_seconds_out,
    output logic [YEAR_W-1:0]   o_year_out,
    output logic [MONTH_W-1:0]  o_month_out,
    output logic [DAY_W-1:0]    o_day_out,
    output logic [HOUR_W-1:0]   o_hour_out,
    output logic [MINUTE_W-1:0] o_minute_out,
    output logic [SECOND_W-1:0] o_second_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    csc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    csc_dp #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_op),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .i_seconds_in  (i_seconds_in),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_seconds_out (o_seconds_out),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_hour_out    (o_hour_out),
        .o_minute_out  (o_minute_out),
        .o_second_out  (o_second_out)
    );

endmodule

// ----- bench/calendar_seconds_converter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the calendar seconds converter: predicts each conversion and compares results.
// Watches both valid/ready channels of calendar_seconds_converter_top; depends on csc_pkg.
module calendar_seconds_converter_checker import csc_pkg::*; #(
    parameter int EPOCH_YEAR = EPOCH_YEAR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready_in,
    input  logic                i_op,
    input  logic [YEAR_W-1:0]   i_year_in,
    input  logic [MONTH_W-1:0]  i_month_in,
    input  logic [DAY_W-1:0]    i_day_in,
    input  logic [HOUR_W-1:0]   i_hour_in,
    input  logic [MINUTE_W-1:0] i_minute_in,
    input  logic [SECOND_W-1:0] i_second_in,
    input  logic [SECS_W-1:0]   i_seconds_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [SECS_W-1:0]   i_seconds_out,
    input  logic [YEAR_W-1:0]   i_year_out,
    input  logic [MONTH_W-1:0]  i_month_out,
    input  logic [DAY_W-1:0]    i_day_out,
    input  logic [HOUR_W-1:0]   i_hour_out,
    input  logic [MINUTE_W-1:0] i_minute_out,
    input  logic [SECOND_W-1:0] i_second_out,
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct packed {
        logic [SECS_W-1:0]   secs;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_conv;

    t_conv awaited_q[$];
    int    mismatches  = 0;
    int    outstanding = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;

    function automatic bit leap_year(input logic [31:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic logic [31:0] month_length(input logic [31:0] m, input logic [31:0] y);
        logic [31:0] len;
        case (m)
            2: len = leap_year(y) ? 32'd29 : 32'd28;
            4, 6, 9, 11: len = 32'd30;
            1, 3, 5, 7, 8, 10, 12: len = 32'd31;
            default: len = 32'd0;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] year_length(input logic [31:0] y);
        return leap_year(y) ? 32'd366 : 32'd365;
    endfunction

    function automatic t_conv convert_item(
        input logic                op,
        input logic [YEAR_W-1:0]   yr,
        input logic [MONTH_W-1:0]  mo,
        input logic [DAY_W-1:0]    dy,
        input logic [HOUR_W-1:0]   hr,
        input logic [MINUTE_W-1:0] mi,
        input logic [SECOND_W-1:0] se,
        input logic [SECS_W-1:0]   secs_in
    );
        t_conv       res;
        logic [31:0] y;
        logic [31:0] m;
        logic [31:0] days;
        logic [31:0] s;
        logic [31:0] delta;
        logic [31:0] dnum;
        res  = '0;
        y    = EPOCH_YEAR;
        m    = 1;
        days = 0;
        if (!op) begin
            if (yr != 0 || mo != 0 || dy != 0 || hr != 0 || mi != 0 || se != 0) begin
                while (y < yr) begin
                    days = days + year_length(y);
                    y = y + 1;
                end
                // The month table uses the year the loop stopped on, the epoch for early years.
                for (m = 1; m < mo; m++) begin
                    days = days + month_length(m, y);
                end
                days = days + {27'd0, dy} - 32'd1;
                res.secs = days * 32'd86400 + {27'd0, hr} * 32'd3600
                         + {26'd0, mi} * 32'd60 + {26'd0, se};
            end
        end else begin
            s = secs_in;
            while (s > 0) begin
                delta = year_length(y) * 32'd86400;
                if (s < delta) break;
                s = s - delta;
                y = y + 1;
            end
            while (s > 0 && m <= 12) begin
                delta = month_length(m, y) * 32'd86400;
                if (s < delta) break;
                s = s - delta;
                m = m + 1;
            end
            dnum       = s / 32'd86400 + 32'd1;
            res.year   = y[YEAR_W-1:0];
            res.month  = m[MONTH_W-1:0];
            res.day    = dnum[DAY_W-1:0];
            s          = s % 32'd86400;
            dnum       = s / 32'd3600;
            res.hour   = dnum[HOUR_W-1:0];
            s          = s % 32'd3600;
            dnum       = s / 32'd60;
            res.minute = dnum[MINUTE_W-1:0];
            dnum       = s % 32'd60;
            res.second = dnum[SECOND_W-1:0];
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        t_conv want;
        if (i_rst_n) begin
            // The result leaving now belongs to an earlier transfer, so pop before pushing.
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    report("result with nothing awaited", i_seconds_out, 0);
                end else begin
                    want = awaited_q.pop_front();
                    outstanding = outstanding - 1;
                    if (i_seconds_out !== want.secs) report("seconds", i_seconds_out, want.secs);
                    if (i_year_out !== want.year) report("year", i_year_out, want.year);
                    if (i_month_out !== want.month) report("month", i_month_out, want.month);
                    if (i_day_out !== want.day) report("day", i_day_out, want.day);
                    if (i_hour_out !== want.hour) report("hour", i_hour_out, want.hour);
                    if (i_minute_out !== want.minute) begin
                        report("minute", i_minute_out, want.minute);
                    end
                    if (i_second_out !== want.second) begin
                        report("second", i_second_out, want.second);
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                awaited_q.push_back(convert_item(i_op, i_year_in, i_month_in, i_day_in,
                                                 i_hour_in, i_minute_in, i_second_in,
                                                 i_seconds_in));
                outstanding = outstanding + 1;
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the calendar seconds converter bench: clock, reset, stimulus and verdict.
// Instantiates calendar_seconds_converter_top and calendar_seconds_converter_checker.
module testbench import csc_pkg::*;;

    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 20000000;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    logic                i_op         = 1'b0;
    logic [YEAR_W-1:0]   i_year_in    = '0;
    logic [MONTH_W-1:0]  i_month_in   = '0;
    logic [DAY_W-1:0]    i_day_in     = '0;
    logic [HOUR_W-1:0]   i_hour_in    = '0;
    logic [MINUTE_W-1:0] i_minute_in  = '0;
    logic [SECOND_W-1:0] i_second_in  = '0;
    logic [SECS_W-1:0]   i_seconds_in = '0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    logic [SECS_W-1:0]   o_seconds_out;
    logic [YEAR_W-1:0]   o_year_out;
    logic [MONTH_W-1:0]  o_month_out;
    logic [DAY_W-1:0]    o_day_out;
    logic [HOUR_W-1:0]   o_hour_out;
    logic [MINUTE_W-1:0] o_minute_out;
    logic [SECOND_W-1:0] o_second_out;

    int errors;
    int pending;
    int cycle_count = 0;
    bit send_calm   = 1'b0;
    bit recv_calm   = 1'b0;

    always #4 i_clk = ~i_clk;

    calendar_seconds_converter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .i_seconds_in  (i_seconds_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_seconds_out (o_seconds_out),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_hour_out    (o_hour_out),
        .o_minute_out  (o_minute_out),
        .o_second_out  (o_second_out)
    );

    calendar_seconds_converter_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_op          (i_op),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .i_seconds_in  (i_seconds_in),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_seconds_out (o_seconds_out),
        .i_year_out    (o_year_out),
        .i_month_out   (o_month_out),
        .i_day_out     (o_day_out),
        .i_hour_out    (o_hour_out),
        .i_minute_out  (o_minute_out),
        .i_second_out  (o_second_out),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The checker updates its count at the rising edge, so it is read at the falling edge.
    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Called and returning at a rising edge; returns at the edge of the transfer.
    task automatic send(
        input logic                op,
        input logic [YEAR_W-1:0]   yr,
        input logic [MONTH_W-1:0]  mo,
        input logic [DAY_W-1:0]    dy,
        input logic [HOUR_W-1:0]   hr,
        input logic [MINUTE_W-1:0] mi,
        input logic [SECOND_W-1:0] se,
        input logic [SECS_W-1:0]   secs,
        input bit                  drain
    );
        int unsigned gap;
        if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (drain || gap > 0) i_valid <= 1'b0;
        if (drain) begin
            wait_drained();
            @(posedge i_clk);
        end
        repeat (gap) @(posedge i_clk);
        i_op         <= op;
        i_year_in    <= yr;
        i_month_in   <= mo;
        i_day_in     <= dy;
        i_hour_in    <= hr;
        i_minute_in  <= mi;
        i_second_in  <= se;
        i_seconds_in <= secs;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Result side: a fresh stall before each result transfer.
    initial begin
        int unsigned stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int unsigned         n;
        bit                  drain;
        logic [SECS_W-1:0]   secs;
        logic [YEAR_W-1:0]   yr;
        logic [MONTH_W-1:0]  mo;
        logic [DAY_W-1:0]    dy;
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mi;
        logic [SECOND_W-1:0] se;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Date to seconds: empty time, the epoch itself, years before the epoch,
        // month zero, one and past twelve, day zero, and out-of-range time fields.
        send(1'b0, 12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  32'd0, 1'b0);
        send(1'b0, 12'd1999, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  32'd0, 1'b0);
        send(1'b0, 12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd1,  32'd0, 1'b0);
        send(1'b0, 12'd1500, 4'd3,  5'd15, 5'd12, 6'd30, 6'd30, 32'd0, 1'b0);
        send(1'b0, 12'd2000, 4'd0,  5'd10, 5'd1,  6'd2,  6'd3,  32'd0, 1'b0);
        send(1'b0, 12'd2000, 4'd1,  5'd31, 5'd23, 6'd59, 6'd59, 32'd0, 1'b0);
        send(1'b0, 12'd2000, 4'd13, 5'd1,  5'd0,  6'd0,  6'd0,  32'd0, 1'b0);
        send(1'b0, 12'd2024, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'd0, 1'b0);
        send(1'b0, 12'd2000, 4'd3,  5'd0,  5'd0,  6'd0,  6'd0,  32'd0, 1'b0);
        send(1'b0, 12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  32'd0, 1'b0);
        send(1'b0, 12'd2400, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  32'd0, 1'b0);
        send(1'b0, 12'd2135, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0, 1'b0);
        send(1'b0, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0);

        // Seconds to date: zero, year and leap-day boundaries, and the top of the range.
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0,        1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd1,        1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd86399,    1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd31535999, 1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd31536000, 1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd36633599, 1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd36633600, 1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd63158400, 1'b0);
        send(1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'h8000_0000, 1'b0);
        send(1'b1, 12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 1'b0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            drain = (n == RANDOM_ITEMS / 3) || (n == 2 * RANDOM_ITEMS / 3);
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 3))
                    0: secs = $urandom_range(0, 200000);
                    1: secs = $urandom_range(0, 1000000000);
                    default: secs = $urandom;
                endcase
                yr = YEAR_W'($urandom_range(0, 4095));
                mo = MONTH_W'($urandom_range(0, 15));
                dy = DAY_W'($urandom_range(0, 31));
                hr = HOUR_W'($urandom_range(0, 31));
                mi = MINUTE_W'($urandom_range(0, 63));
                se = SECOND_W'($urandom_range(0, 63));
            end else begin
                secs = $urandom;
                if ($urandom_range(0, 9) < 8) begin
                    yr = YEAR_W'($urandom_range(1995, 2140));
                    mo = MONTH_W'($urandom_range(1, 12));
                    dy = DAY_W'($urandom_range(1, 31));
                    hr = HOUR_W'($urandom_range(0, 23));
                    mi = MINUTE_W'($urandom_range(0, 59));
                    se = SECOND_W'($urandom_range(0, 59));
                end else begin
                    // Far-future years are slow, so only a few of them.
                    yr = YEAR_W'(($urandom_range(0, 29) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(0, 2200));
                    mo = MONTH_W'($urandom_range(0, 15));
                    dy = DAY_W'($urandom_range(0, 31));
                    hr = HOUR_W'($urandom_range(0, 31));
                    mi = MINUTE_W'($urandom_range(0, 63));
                    se = SECOND_W'($urandom_range(0, 63));
                end
            end
            send(1'($urandom_range(0, 1)), yr, mo, dy, hr, mi, se, secs, drain);
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
